@@ design/mfhv_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI file header validator package
// Item types, parser phases, verdict codes and header constants.
// ----------------------------------------------------------------------------
package mfhv_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        file_format;
    logic [15:0] track_count;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HDR_TAG  = 3'd0,
    PH_HDR_LEN  = 3'd1,
    PH_FORMAT   = 3'd2,
    PH_COUNT    = 3'd3,
    PH_TRK_TAG  = 3'd4,
    PH_TRK_LEN  = 3'd5,
    PH_TRK_BODY = 3'd6,
    PH_DONE     = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_NOTMIDI = 3'd2,
    ST_UNSUP   = 3'd3,
    ST_BADEOT  = 3'd4
  } status_e;

  localparam logic [31:0] TagHeader  = 32'h4D54_6864;
  localparam logic [31:0] TagTrack   = 32'h4D54_726B;
  localparam logic [31:0] MinFileLen = 32'd25;
  localparam logic [31:0] HdrLen     = 32'd6;
  localparam logic [23:0] EotMark    = 24'hFF_2F00;

endpackage

@@ design/mfhv_parser.sv @@
// ----------------------------------------------------------------------------
// MIDI file header validator parser
// Byte-wide parser state and its per-byte update; gives the verdict on
// the last byte of a file and then clears for the next one.
// ----------------------------------------------------------------------------
module mfhv_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mfhv_pkg::in_item_t item_i,
  input  logic [31:0]        file_length_i,
  output logic               res_valid_o,
  output mfhv_pkg::out_item_t res_o
);

  mfhv_pkg::phase_e  phase_q, phase_d;
  mfhv_pkg::status_e verdict_q, verdict_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] bc_q, bc_d;
  logic        fmt_q, fmt_d;
  logic [15:0] decl_q, decl_d;
  logic [15:0] fin_q, fin_d;
  logic [31:0] left_q, left_d;
  logic [23:0] tail_q, tail_d;

  logic [31:0] acc_shift;
  logic [1:0]  idx_inc;
  logic        done4, done2;
  logic [31:0] bc_inc;
  logic [32:0] len_sum;
  logic        len_short;

  always_comb begin
    acc_shift = {acc_q[23:0], item_i.data_byte};
    idx_inc   = idx_q + 2'd1;
    done4     = (idx_inc == 2'd0);
    done2     = (idx_inc == 2'd2);
    bc_inc    = (bc_q == '1) ? bc_q : bc_q + 32'd1;
    len_sum   = {1'b0, acc_shift} + {1'b0, bc_inc};
    len_short = (acc_shift != 32'd0) && (len_sum > {1'b0, file_length_i});

    phase_d   = phase_q;
    verdict_d = verdict_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    bc_d      = bc_q;
    fmt_d     = fmt_q;
    decl_d    = decl_q;
    fin_d     = fin_q;
    left_d    = left_q;
    tail_d    = tail_q;

    res_valid_o       = 1'b0;
    res_o.status      = mfhv_pkg::ST_OK;
    res_o.file_format = 1'b0;
    res_o.track_count = '0;

    if (step_i) begin
      bc_d = bc_inc;
      if (verdict_q == mfhv_pkg::ST_OK && phase_q != mfhv_pkg::PH_DONE) begin
        if (file_length_i < mfhv_pkg::MinFileLen) begin
          verdict_d = mfhv_pkg::ST_SHORT;
        end else begin
          case (phase_q)
            mfhv_pkg::PH_HDR_TAG: begin
              acc_d = acc_shift;
              idx_d = done4 ? 2'd0 : idx_inc;
              if (done4) begin
                if (acc_shift != mfhv_pkg::TagHeader) verdict_d = mfhv_pkg::ST_NOTMIDI;
                else phase_d = mfhv_pkg::PH_HDR_LEN;
              end
            end
            mfhv_pkg::PH_HDR_LEN: begin
              acc_d = acc_shift;
              idx_d = done4 ? 2'd0 : idx_inc;
              if (done4) begin
                if (acc_shift != mfhv_pkg::HdrLen) verdict_d = mfhv_pkg::ST_NOTMIDI;
                else phase_d = mfhv_pkg::PH_FORMAT;
              end
            end
            mfhv_pkg::PH_FORMAT: begin
              acc_d = acc_shift;
              idx_d = done2 ? 2'd0 : idx_inc;
              if (done2) begin
                if (acc_shift[15:0] > 16'd1) begin
                  verdict_d = mfhv_pkg::ST_UNSUP;
                end else begin
                  fmt_d   = acc_shift[0];
                  phase_d = mfhv_pkg::PH_COUNT;
                end
              end
            end
            mfhv_pkg::PH_COUNT: begin
              acc_d = acc_shift;
              idx_d = done2 ? 2'd0 : idx_inc;
              if (done2) begin
                decl_d = acc_shift[15:0];
                if (acc_shift[15:0] == 16'd0 || (!fmt_q && acc_shift[15:0] > 16'd1)) begin
                  verdict_d = mfhv_pkg::ST_UNSUP;
                end else begin
                  phase_d = mfhv_pkg::PH_TRK_TAG;
                end
              end
            end
            mfhv_pkg::PH_TRK_TAG: begin
              acc_d = acc_shift;
              idx_d = done4 ? 2'd0 : idx_inc;
              if (done4) begin
                if (acc_shift != mfhv_pkg::TagTrack) verdict_d = mfhv_pkg::ST_NOTMIDI;
                else phase_d = mfhv_pkg::PH_TRK_LEN;
              end
            end
            mfhv_pkg::PH_TRK_LEN: begin
              acc_d = acc_shift;
              idx_d = done4 ? 2'd0 : idx_inc;
              if (done4) begin
                if (len_short) begin
                  verdict_d = mfhv_pkg::ST_SHORT;
                end else if (acc_shift < 32'd3) begin
                  verdict_d = mfhv_pkg::ST_BADEOT;
                end else begin
                  left_d  = acc_shift;
                  tail_d  = '0;
                  phase_d = mfhv_pkg::PH_TRK_BODY;
                end
              end
            end
            mfhv_pkg::PH_TRK_BODY: begin
              tail_d = {tail_q[15:0], item_i.data_byte};
              left_d = left_q - 32'd1;
              if (left_d == 32'd0) begin
                if (tail_d != mfhv_pkg::EotMark) begin
                  verdict_d = mfhv_pkg::ST_BADEOT;
                end else begin
                  fin_d   = fin_q + 16'd1;
                  phase_d = (fin_d == decl_q) ? mfhv_pkg::PH_DONE : mfhv_pkg::PH_TRK_TAG;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      if (item_i.last_byte) begin
        res_valid_o       = 1'b1;
        res_o.status      = (verdict_d == mfhv_pkg::ST_OK && phase_d != mfhv_pkg::PH_DONE)
                            ? mfhv_pkg::ST_SHORT : verdict_d;
        res_o.file_format = fmt_d;
        res_o.track_count = decl_d;
        // new file starts with the next item
        phase_d   = mfhv_pkg::PH_HDR_TAG;
        verdict_d = mfhv_pkg::ST_OK;
        idx_d     = '0;
        acc_d     = '0;
        bc_d      = '0;
        fmt_d     = 1'b0;
        decl_d    = '0;
        fin_d     = '0;
        left_d    = '0;
        tail_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mfhv_pkg::PH_HDR_TAG;
      verdict_q <= mfhv_pkg::ST_OK;
      idx_q     <= '0;
      acc_q     <= '0;
      bc_q      <= '0;
      fmt_q     <= 1'b0;
      decl_q    <= '0;
      fin_q     <= '0;
      left_q    <= '0;
      tail_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      verdict_q <= verdict_d;
      idx_q     <= idx_d;
      acc_q     <= acc_d;
      bc_q      <= bc_d;
      fmt_q     <= fmt_d;
      decl_q    <= decl_d;
      fin_q     <= fin_d;
      left_q    <= left_d;
      tail_q    <= tail_d;
    end
  end

  // all tracks done only on a clean parse
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mfhv_pkg::PH_DONE |-> verdict_q == mfhv_pkg::ST_OK)
    else $error("done phase with error verdict");

  // a track body still being parsed always has bytes to go
  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mfhv_pkg::PH_TRK_BODY && verdict_q == mfhv_pkg::ST_OK) |-> left_q != 32'd0)
    else $error("track body with no bytes left");

  a_fin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= decl_q)
    else $error("more tracks finished than declared");

  a_res_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == mfhv_pkg::PH_HDR_TAG && bc_q == 32'd0))
    else $error("parse state not cleared after verdict");

endmodule

@@ design/midi_file_header_validator.sv @@
// ----------------------------------------------------------------------------
// MIDI file header validator
// Checks the header and track framing of a Standard MIDI File streamed one
// byte per item and gives one verdict item on the byte marked last.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes into the input register, then the parser update
// writes the verdict into the output register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears pipeline valids, parser state and
// file_length to 0.
module midi_file_header_validator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfhv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfhv_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic                in_valid_q, in_valid_d;
  mfhv_pkg::in_item_t  in_item_q;
  logic                out_valid_q, out_valid_d;
  mfhv_pkg::out_item_t out_item_q;
  logic [31:0]         file_length_q;
  logic                advance;
  logic                res_valid;
  mfhv_pkg::out_item_t res;

  assign advance     = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  mfhv_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .file_length_i(file_length_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) in_valid_d = 1'b1;
    else if (advance)              in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (res_valid)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      file_length_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) file_length_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_item_q  <= in_item_i;
    if (res_valid)                 out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
